@@ rtl/lruft_pkg.sv @@
// ----------------------------------------------------------------------------
// lruft_pkg
// Shared sizes, types and command struct of the fully associative LRU tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package lruft_pkg;

    // tracker geometry
    localparam int ENTRIES  = 16;
    localparam int KEY_BITS = 32;

    // derived widths
    localparam int RANK_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W  = $clog2(ENTRIES + 1);

    // fixed field widths of the stream and configuration ports
    localparam int IN_KEY_W  = 32;
    localparam int OUT_KEY_W = 32;
    localparam int SLOT_W    = 4;
    localparam int CAP_W     = 5;
    localparam int M_TDATA_W = 40;
    localparam int M_PAD_W   = M_TDATA_W - SLOT_W - OUT_KEY_W;
    localparam int M_TUSER_W = 2;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    typedef logic [KEY_BITS-1:0]  key_t;
    typedef logic [RANK_W-1:0]    rank_t;
    typedef logic [CNT_W-1:0]     cnt_t;
    typedef logic [SLOT_W-1:0]    slot_t;
    typedef logic [OUT_KEY_W-1:0] okey_t;
    typedef logic [CAP_W-1:0]     cap_t;

    // controller to datapath commands
    typedef struct packed {
        logic capture;  // latch the incoming key
        logic lookup;   // compare against all live ranks, register the outcome
        logic commit;   // move to front and load the result register
    } cmd_t;

endpackage

`default_nettype wire

@@ rtl/lruft_ctrl.sv @@
// ----------------------------------------------------------------------------
// lruft_ctrl
// Sequencer of the tracker: capture, lookup, commit, and result valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module lruft_ctrl (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            s_tvalid,
    output logic                 s_tready,
    output logic                 m_tvalid,
    input  wire logic            m_tready,
    output lruft_pkg::cmd_t      cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_COMMIT
    } state_t;

    state_t state_reg, state_next;
    logic   m_tvalid_reg, m_tvalid_next;

    // commands decoded from the current state
    always_comb begin
        cmd.capture = (state_reg == ST_IDLE) && s_tvalid;
        cmd.lookup  = (state_reg == ST_LOOKUP);
        cmd.commit  = (state_reg == ST_COMMIT) && (!m_tvalid_reg || m_tready);
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;

    // next state and result valid
    always_comb begin
        state_next    = state_reg;
        m_tvalid_next = m_tvalid_reg;
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP: begin
                state_next = ST_COMMIT;
            end
            ST_COMMIT: begin
                if (cmd.commit) begin
                    state_next    = ST_IDLE;
                    m_tvalid_next = 1'b1;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // at most one command per cycle
    a_cmd_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.capture, cmd.lookup, cmd.commit}))
        else $error("controller issued overlapping commands");

    // a commit never overwrites a result still waiting
    a_commit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |-> (!m_tvalid_reg || m_tready))
        else $error("commit while result register is occupied");

    // a captured key is looked up in the next cycle
    a_capture_lookup: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.capture |=> cmd.lookup)
        else $error("captured key not looked up");

endmodule

`default_nettype wire

@@ rtl/lruft_datapath.sv @@
// ----------------------------------------------------------------------------
// lruft_datapath
// Recency-ordered key and slot ranks, parallel match, move-to-front shift.
// ----------------------------------------------------------------------------
`default_nettype none

module lruft_datapath (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire lruft_pkg::cmd_t                       cmd,
    input  wire logic [lruft_pkg::IN_KEY_W-1:0]        s_tdata,
    input  wire logic                                  cfg_valid,
    input  wire logic [lruft_pkg::CAP_W-1:0]           cfg_data,
    output logic      [lruft_pkg::M_TDATA_W-1:0]       m_tdata,
    output logic      [lruft_pkg::M_TUSER_W-1:0]       m_tuser
);

    // rank storage, rank 0 most recent
    lruft_pkg::key_t  keys_reg  [lruft_pkg::ENTRIES];
    lruft_pkg::rank_t slots_reg [lruft_pkg::ENTRIES];
    lruft_pkg::cnt_t  live_reg, live_next;
    lruft_pkg::cap_t  cap_reg;
    lruft_pkg::key_t  key_reg;

    // lookup outcome
    lruft_pkg::rank_t pos_reg, pos_next;
    logic             hit_reg, hit_next;
    logic             evict_reg, evict_next;
    logic             grow_reg, grow_next;

    // result register
    logic             out_hit_reg;
    logic             out_evict_reg;
    lruft_pkg::slot_t out_slot_reg;
    lruft_pkg::okey_t out_key_reg;

    lruft_pkg::cnt_t  eff_cap;
    logic [lruft_pkg::ENTRIES-1:0] match;
    logic [lruft_pkg::ENTRIES-1:0] slot_seen;

    // capacity clamped to the range 1..ENTRIES
    always_comb begin
        if (cap_reg == '0) begin
            eff_cap = lruft_pkg::cnt_t'(1);
        end else if (int'(cap_reg) > lruft_pkg::ENTRIES) begin
            eff_cap = lruft_pkg::cnt_t'(lruft_pkg::ENTRIES);
        end else begin
            eff_cap = lruft_pkg::cnt_t'(cap_reg);
        end
    end

    // capacity register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg <= lruft_pkg::CAP_RESET;
        end else if (cfg_valid) begin
            cap_reg <= cfg_data;
        end
    end

    // key capture
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            key_reg <= lruft_pkg::key_t'(s_tdata);
        end
    end

    // parallel compare over live ranks, lowest rank wins
    always_comb begin
        for (int r = 0; r < lruft_pkg::ENTRIES; r++) begin
            match[r] = (lruft_pkg::cnt_t'(r) < live_reg) && (keys_reg[r] == key_reg);
        end
        hit_next   = |match;
        pos_next   = '0;
        evict_next = 1'b0;
        grow_next  = 1'b0;
        for (int r = lruft_pkg::ENTRIES - 1; r >= 0; r--) begin
            if (match[r]) begin
                pos_next = lruft_pkg::rank_t'(r);
            end
        end
        if (!hit_next) begin
            if ((live_reg >= eff_cap) && (live_reg != '0)) begin
                pos_next   = lruft_pkg::rank_t'(live_reg - lruft_pkg::cnt_t'(1));
                evict_next = 1'b1;
            end else begin
                pos_next  = lruft_pkg::rank_t'(live_reg);
                grow_next = 1'b1;
            end
        end
    end

    // lookup outcome register
    always_ff @(posedge aclk) begin
        if (cmd.lookup) begin
            pos_reg   <= pos_next;
            hit_reg   <= hit_next;
            evict_reg <= evict_next;
            grow_reg  <= grow_next;
        end
    end

    // move-to-front shift of keys
    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            keys_reg[0] <= key_reg;
            for (int r = 1; r < lruft_pkg::ENTRIES; r++) begin
                if (lruft_pkg::rank_t'(r) <= pos_reg) begin
                    keys_reg[r] <= keys_reg[r-1];
                end
            end
        end
    end

    // move-to-front shift of slots, reset to the identity order
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int r = 0; r < lruft_pkg::ENTRIES; r++) begin
                slots_reg[r] <= lruft_pkg::rank_t'(r);
            end
        end else if (cmd.commit) begin
            slots_reg[0] <= slots_reg[pos_reg];
            for (int r = 1; r < lruft_pkg::ENTRIES; r++) begin
                if (lruft_pkg::rank_t'(r) <= pos_reg) begin
                    slots_reg[r] <= slots_reg[r-1];
                end
            end
        end
    end

    // live entry count
    always_comb begin
        live_next = live_reg;
        if (cmd.commit && grow_reg) begin
            live_next = live_reg + lruft_pkg::cnt_t'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            live_reg <= '0;
        end else begin
            live_reg <= live_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            out_hit_reg   <= hit_reg;
            out_evict_reg <= evict_reg;
            out_slot_reg  <= lruft_pkg::slot_t'(slots_reg[pos_reg]);
            out_key_reg   <= evict_reg ? lruft_pkg::okey_t'(keys_reg[pos_reg]) : '0;
        end
    end

    assign m_tdata = {{lruft_pkg::M_PAD_W{1'b0}}, out_key_reg, out_slot_reg};
    assign m_tuser = {out_evict_reg, out_hit_reg};

    // slot table coverage, used to check it stays a permutation
    always_comb begin
        slot_seen = '0;
        for (int r = 0; r < lruft_pkg::ENTRIES; r++) begin
            slot_seen[slots_reg[r]] = 1'b1;
        end
    end

    a_live_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        int'(live_reg) <= lruft_pkg::ENTRIES)
        else $error("live count beyond table size");

    a_slot_perm: assert property (@(posedge aclk) disable iff (!aresetn)
        &slot_seen)
        else $error("slot table is not a permutation");

    a_grow_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.commit && grow_reg) |=> (live_reg == $past(live_reg) + lruft_pkg::cnt_t'(1)))
        else $error("live count did not advance on a fresh slot");

endmodule

`default_nettype wire

@@ rtl/lru_fully_associative_tracker.sv @@
// ----------------------------------------------------------------------------
// lru_fully_associative_tracker
// Fully associative LRU tracker: hit/miss, slot, and evicted key per lookup.
// ----------------------------------------------------------------------------
// Sequence: the input key is captured, compared over all live ranks, then
//   committed move-to-front into the result register.
// A new lookup is accepted only once the previous one has committed, in
//   capture/compare/commit order; a result not taken holds the commit step.
// Reset: synchronous active-low; empties the tracker, restores slot order
//   and sets capacity to 16. No clearing pass is needed.
`default_nettype none

module lru_fully_associative_tracker (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    // lookup_key[31:0]
    input  wire logic [lruft_pkg::IN_KEY_W-1:0]      s_tdata,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    // slot[3:0], evicted_key[35:4], zero pad[39:36]
    output logic      [lruft_pkg::M_TDATA_W-1:0]     m_tdata,
    // hit[0], evicted_valid[1]
    output logic      [lruft_pkg::M_TUSER_W-1:0]     m_tuser,
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // capacity[4:0]
    input  wire logic [lruft_pkg::CAP_W-1:0]         cfg_data,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready
);

    lruft_pkg::cmd_t cmd;

    assign cfg_ready = 1'b1;

    // sequencer
    lruft_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    // rank storage and compare
    lruft_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .s_tdata   (s_tdata),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

`default_nettype wire
